// File: rtl/core/bbfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfs_pkg
// Types, command codes and helpers shared by the byte/bit field serializer.
// ----------------------------------------------------------------------------
package bbfs_pkg;

    localparam int LIMIT_W = 11;

    // Item kinds
    localparam logic [2:0] KIND_BEGIN     = 3'd0;
    localparam logic [2:0] KIND_BYTES     = 3'd1;
    localparam logic [2:0] KIND_BITS      = 3'd2;
    localparam logic [2:0] KIND_SHORT     = 3'd3;
    localparam logic [2:0] KIND_LOAD_BYTE = 3'd4;
    localparam logic [2:0] KIND_LOAD_BIT  = 3'd5;

    // Configuration register indexes (paddr[2])
    localparam logic REG_BYTE_LIMIT = 1'b0;
    localparam logic REG_BIT_LIMIT  = 1'b1;

    localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;
    localparam logic [5:0] MAX_FIELD_BITS  = 6'd32;
    localparam logic signed [15:0] SHORT_MAG_MAX = 16'sd255;

    typedef struct packed {
        logic [2:0]  kind;
        logic        write_mode;
        logic [63:0] value;
        logic [3:0]  width_bytes;
        logic [5:0]  bit_count;
        logic [9:0]  load_address;
    } cmd_t;

    typedef struct packed {
        logic [63:0]        read_value;
        logic               ok;
        logic               error_seen;
        logic [LIMIT_W-1:0] byte_position;
        logic [LIMIT_W-1:0] bit_position;
    } rsp_t;

    // Low n bits set, n saturates at 32
    function automatic logic [31:0] mask32(input logic [5:0] n);
        logic [31:0] m;
        if (n >= MAX_FIELD_BITS)
            m = 32'hFFFF_FFFF;
        else
            m = (32'd1 << n) - 32'd1;
        return m;
    endfunction

endpackage

// File: rtl/core/byte_and_bit_field_serializer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_and_bit_field_serializer_core
// Packet field codec over a byte store and a bit store, each with a cursor.
// A small sequencer moves one store byte per step through a shared byte
// lane: byte fields one byte a cycle, bit fields by read-modify-write.
// ----------------------------------------------------------------------------
//  Channel   | Signals                          | Transaction
//  ----------+----------------------------------+--------------------------------
//  command   | start, busy, item                | start && !busy at clk rise
//  result    | done, result                     | done high for one cycle
//  config    | psel, penable, pwrite, paddr,    | APB write, pready tied high
//            | pwdata, prdata, pready           |
//
//  From command transaction to done strobe, every command passes decode
//  and finish; begin, loads, unused kinds and errors found at decode do
//  nothing else. A byte field adds one byte step per byte, plus a drain
//  step when reading; a bit field adds a read and a write-back step per
//  store byte it spans; a compressed short adds both, plus a flag peek when reading.
//  Reset clears cursors, mode, error flag and bit store valid bits; the
//  byte store is not cleared. The receiver cannot stall; busy drops as
//  done rises, so the next command may follow in that cycle.
// ----------------------------------------------------------------------------
module byte_and_bit_field_serializer_core #(
    parameter int BYTE_DEPTH = 1024,
    parameter int BIT_DEPTH  = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bbfs_pkg::cmd_t item,
    output logic          done,
    output bbfs_pkg::rsp_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import bbfs_pkg::*;

    localparam int BIT_BYTES = (BIT_DEPTH + 7) / 8;
    localparam int BYTE_AW   = $clog2(BYTE_DEPTH);
    localparam int BIT_AW    = (BIT_BYTES > 1) ? $clog2(BIT_BYTES) : 1;
    localparam int BCW       = $clog2(BYTE_DEPTH + 1);
    localparam int TCW       = $clog2(BIT_DEPTH + 1);
    localparam int BSW       = BCW + 4;
    localparam int TSW       = TCW + 6;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_PEEK       = 4'd2;
    localparam logic [3:0] S_BIT_RD     = 4'd3;
    localparam logic [3:0] S_BIT_WB     = 4'd4;
    localparam logic [3:0] S_BYTE_OP    = 4'd5;
    localparam logic [3:0] S_BYTE_DRAIN = 4'd6;
    localparam logic [3:0] S_FINISH     = 4'd7;

    // Control state
    logic [3:0]           state_reg, state_next;
    cmd_t                 item_reg, item_next;
    logic                 mode_reg, mode_next;
    logic                 err_reg, err_next;
    logic [BCW-1:0]       byte_cursor_reg, byte_cursor_next;
    logic [TCW-1:0]       bit_cursor_reg, bit_cursor_next;
    logic [LIMIT_W-1:0]   byte_limit_reg, bit_limit_reg;
    logic                 ok_reg, ok_next;
    logic                 big_reg, big_next;
    logic [5:0]           bit_n_reg, bit_n_next;
    logic [3:0]           byte_n_reg, byte_n_next;
    logic [2:0]           bit_nb_reg, bit_nb_next;
    logic [2:0]           bit_j_reg, bit_j_next;
    logic [3:0]           byte_idx_reg, byte_idx_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [2:0]           rd_slot_reg, rd_slot_next;
    logic                 done_reg, done_next;
    rsp_t                 result_reg, result_next;
    logic [BIT_BYTES-1:0] bit_valid_reg, bit_valid_next;

    // Payload registers
    logic [39:0]          bits_reg, bits_next;
    logic [63:0]          acc_reg, acc_next;
    logic [63:0]          val_reg, val_next;

    // Stores
    logic [7:0]           byte_mem [BYTE_DEPTH];
    logic [7:0]           bit_mem  [BIT_BYTES];
    logic [7:0]           byte_rdata_reg;
    logic [7:0]           bit_rdata_reg;
    logic                 bit_rvalid_reg;

    logic                 byte_we;
    logic [BYTE_AW-1:0]   byte_waddr, byte_addr;
    logic [7:0]           byte_wdata;
    logic                 bit_we;
    logic [BIT_AW-1:0]    bit_waddr, bit_addr;
    logic [7:0]           bit_wdata;

    // Datapath
    logic [BCW-1:0]       byte_lim;
    logic [TCW-1:0]       bit_lim;
    logic [2:0]           pofs;
    logic [3:0]           wb;
    logic [5:0]           bc;
    logic signed [15:0]   sv;
    logic [15:0]          mag16;
    logic                 sh_big;
    logic [5:0]           sh_nbits;
    logic [3:0]           sh_nbytes;
    logic [31:0]          sh_bitdata;
    logic [63:0]          sh_bytedata;
    logic                 sh_room;
    logic [5:0]           al_n;
    logic [31:0]          al_data;
    logic [39:0]          al_bits;
    logic [6:0]           al_span;
    logic [2:0]           al_nb;
    logic [7:0]           old_byte;
    logic [31:0]          bitsval;
    logic [15:0]          short_small;
    logic [63:0]          rv;
    logic [31:0]          byte_cur32, bit_cur32;
    logic                 cfg_write;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;

    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_BIT_LIMIT) ? {21'h0, bit_limit_reg}
                                                   : {21'h0, byte_limit_reg};

    // Limits beyond the store depth act as the depth
    assign byte_lim = (32'(byte_limit_reg) > 32'(BYTE_DEPTH)) ? BCW'(BYTE_DEPTH)
                                                              : BCW'(byte_limit_reg);
    assign bit_lim  = (32'(bit_limit_reg) > 32'(BIT_DEPTH)) ? TCW'(BIT_DEPTH)
                                                            : TCW'(bit_limit_reg);

    assign pofs = bit_cursor_reg[2:0];
    assign wb   = (item_reg.width_bytes > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES
                                                           : item_reg.width_bytes;
    assign bc   = (item_reg.bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS
                                                        : item_reg.bit_count;

    assign byte_addr = BYTE_AW'(byte_cursor_reg + BCW'(byte_idx_reg));
    assign bit_addr  = BIT_AW'((bit_cursor_reg >> 3) + TCW'(bit_j_reg));

    assign old_byte = bit_rvalid_reg ? bit_rdata_reg : 8'h00;

    // Compressed short: flag/sign bits and magnitude bytes
    assign sv     = signed'(item_reg.value[15:0]);
    assign mag16  = sv[15] ? (16'h0000 - item_reg.value[15:0]) : item_reg.value[15:0];
    assign sh_big = (state_reg == S_PEEK) ? old_byte[pofs]
                                          : ((sv > SHORT_MAG_MAX) || (sv < -SHORT_MAG_MAX));
    assign sh_nbits    = sh_big ? 6'd1 : 6'd2;
    assign sh_nbytes   = sh_big ? 4'd2 : 4'd1;
    assign sh_bitdata  = sh_big ? 32'd1 : (sv[15] ? 32'd0 : 32'd2);
    assign sh_bytedata = sh_big ? {48'h0, item_reg.value[15:0]} : {56'h0, mag16[7:0]};
    assign sh_room = (TSW'(bit_cursor_reg) + TSW'(sh_nbits) <= TSW'(bit_lim))
                  && (BSW'(byte_cursor_reg) + BSW'(sh_nbytes) <= BSW'(byte_lim));

    // Align a bit field onto store byte lanes
    assign al_n    = (item_reg.kind == KIND_BITS) ? bc : sh_nbits;
    assign al_data = (item_reg.kind == KIND_BITS) ? item_reg.value[31:0] : sh_bitdata;
    assign al_bits = {8'h00, al_data & mask32(al_n)} << pofs;
    assign al_span = 7'(pofs) + 7'(al_n) + 7'd7;
    assign al_nb   = (al_n == 6'd0) ? 3'd0 : al_span[5:3];

    // Read-back values
    assign bitsval     = 32'(bits_reg >> pofs) & mask32(bit_n_reg);
    assign short_small = bitsval[1] ? {8'h00, acc_reg[7:0]}
                                    : (16'h0000 - {8'h00, acc_reg[7:0]});

    always_comb
    begin
        rv = 64'h0;
        case (item_reg.kind)
            KIND_BYTES: rv = acc_reg;
            KIND_BITS:  rv = {32'h0, bitsval};
            KIND_SHORT: rv = big_reg ? acc_reg : {48'h0, short_small};
            default:    rv = 64'h0;
        endcase
        if (mode_reg || !ok_reg)
            rv = 64'h0;
    end

    assign byte_cur32 = 32'(byte_cursor_next);
    assign bit_cur32  = 32'(bit_cursor_next);

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        mode_next        = mode_reg;
        err_next         = err_reg;
        byte_cursor_next = byte_cursor_reg;
        bit_cursor_next  = bit_cursor_reg;
        ok_next          = ok_reg;
        big_next         = big_reg;
        bit_n_next       = bit_n_reg;
        byte_n_next      = byte_n_reg;
        bit_nb_next      = bit_nb_reg;
        bit_j_next       = bit_j_reg;
        byte_idx_next    = byte_idx_reg;
        rd_valid_next    = 1'b0;
        rd_slot_next     = rd_slot_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        bit_valid_next   = bit_valid_reg;
        bits_next        = bits_reg;
        acc_next         = acc_reg;
        val_next         = val_reg;
        byte_we          = 1'b0;
        byte_waddr       = byte_addr;
        byte_wdata       = val_reg[{byte_idx_reg[2:0], 3'b000} +: 8];
        bit_we           = 1'b0;
        bit_waddr        = bit_addr;
        bit_wdata        = old_byte | bits_reg[{bit_j_reg, 3'b000} +: 8];

        // Collect byte store read data in the cycle after issue
        if (rd_valid_reg)
            acc_next[{rd_slot_reg, 3'b000} +: 8] = byte_rdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    bit_j_next = 3'd0;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                ok_next       = 1'b0;
                bit_n_next    = 6'd0;
                byte_n_next   = 4'd0;
                bit_nb_next   = 3'd0;
                byte_idx_next = 4'd0;
                acc_next      = 64'h0;
                state_next    = S_FINISH;
                case (item_reg.kind)
                    KIND_BEGIN:
                    begin
                        mode_next        = item_reg.write_mode;
                        byte_cursor_next = '0;
                        bit_cursor_next  = '0;
                        err_next         = 1'b0;
                        ok_next          = 1'b1;
                        if (item_reg.write_mode)
                            bit_valid_next = '0;
                    end

                    KIND_BYTES:
                    begin
                        if (BSW'(byte_cursor_reg) + BSW'(wb) > BSW'(byte_lim))
                            err_next = 1'b1;
                        else
                        begin
                            ok_next     = 1'b1;
                            byte_n_next = wb;
                            val_next    = item_reg.value;
                            if (wb != 4'd0)
                                state_next = S_BYTE_OP;
                        end
                    end

                    KIND_BITS:
                    begin
                        if ((bit_cursor_reg >= bit_lim)
                            || (TSW'(bit_cursor_reg) + TSW'(bc) > TSW'(bit_lim)))
                            err_next = 1'b1;
                        else
                        begin
                            ok_next     = 1'b1;
                            bit_n_next  = bc;
                            bits_next   = mode_reg ? al_bits : 40'h0;
                            bit_nb_next = al_nb;
                            if (al_nb != 3'd0)
                                state_next = S_BIT_RD;
                        end
                    end

                    KIND_SHORT:
                    begin
                        if (bit_cursor_reg >= bit_lim)
                            err_next = 1'b1;
                        else if (!mode_reg)
                            state_next = S_PEEK;
                        else if (!sh_room)
                            err_next = 1'b1;
                        else
                        begin
                            ok_next     = 1'b1;
                            big_next    = sh_big;
                            bit_n_next  = sh_nbits;
                            bits_next   = al_bits;
                            bit_nb_next = al_nb;
                            byte_n_next = sh_nbytes;
                            val_next    = sh_bytedata;
                            state_next  = S_BIT_RD;
                        end
                    end

                    KIND_LOAD_BYTE:
                    begin
                        if (32'(item_reg.load_address) < 32'(BYTE_DEPTH))
                        begin
                            byte_we    = 1'b1;
                            byte_waddr = BYTE_AW'(item_reg.load_address);
                            byte_wdata = item_reg.value[7:0];
                            ok_next    = 1'b1;
                        end
                    end

                    KIND_LOAD_BIT:
                    begin
                        if (32'(item_reg.load_address) < 32'(BIT_BYTES))
                        begin
                            bit_we    = 1'b1;
                            bit_waddr = BIT_AW'(item_reg.load_address);
                            bit_wdata = item_reg.value[7:0];
                            bit_valid_next[BIT_AW'(item_reg.load_address)] = 1'b1;
                            ok_next   = 1'b1;
                        end
                    end

                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            S_PEEK:
            begin
                // Flag bit of the stored short decides its length
                if (!sh_room)
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    ok_next     = 1'b1;
                    big_next    = sh_big;
                    bit_n_next  = sh_nbits;
                    bits_next   = 40'h0;
                    bit_nb_next = al_nb;
                    byte_n_next = sh_nbytes;
                    val_next    = 64'h0;
                    state_next  = S_BIT_RD;
                end
            end

            S_BIT_RD:
            begin
                state_next = S_BIT_WB;
            end

            S_BIT_WB:
            begin
                if (mode_reg)
                begin
                    bit_we = 1'b1;
                    bit_valid_next[bit_addr] = 1'b1;
                end
                else
                    bits_next[{bit_j_reg, 3'b000} +: 8] = old_byte;
                bit_j_next = 3'(bit_j_reg + 3'd1);
                if (3'(bit_j_reg + 3'd1) == bit_nb_reg)
                    state_next = (byte_n_reg != 4'd0) ? S_BYTE_OP : S_FINISH;
                else
                    state_next = S_BIT_RD;
            end

            S_BYTE_OP:
            begin
                if (mode_reg)
                    byte_we = 1'b1;
                else
                begin
                    rd_valid_next = 1'b1;
                    rd_slot_next  = byte_idx_reg[2:0];
                end
                byte_idx_next = 4'(byte_idx_reg + 4'd1);
                if (4'(byte_idx_reg + 4'd1) == byte_n_reg)
                    state_next = mode_reg ? S_FINISH : S_BYTE_DRAIN;
            end

            S_BYTE_DRAIN:
            begin
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                byte_cursor_next = BCW'(byte_cursor_reg + BCW'(byte_n_reg));
                bit_cursor_next  = TCW'(bit_cursor_reg + TCW'(bit_n_reg));
                result_next.read_value    = rv;
                result_next.ok            = ok_reg;
                result_next.error_seen    = err_reg;
                result_next.byte_position = byte_cur32[LIMIT_W-1:0];
                result_next.bit_position  = bit_cur32[LIMIT_W-1:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= 1'b0;
            err_reg         <= 1'b0;
            byte_cursor_reg <= '0;
            bit_cursor_reg  <= '0;
            byte_limit_reg  <= 11'd1024;
            bit_limit_reg   <= 11'd1024;
            ok_reg          <= 1'b0;
            big_reg         <= 1'b0;
            bit_n_reg       <= 6'd0;
            byte_n_reg      <= 4'd0;
            bit_nb_reg      <= 3'd0;
            bit_j_reg       <= 3'd0;
            byte_idx_reg    <= 4'd0;
            rd_valid_reg    <= 1'b0;
            rd_slot_reg     <= 3'd0;
            done_reg        <= 1'b0;
            bit_valid_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            err_reg         <= err_next;
            byte_cursor_reg <= byte_cursor_next;
            bit_cursor_reg  <= bit_cursor_next;
            ok_reg          <= ok_next;
            big_reg         <= big_next;
            bit_n_reg       <= bit_n_next;
            byte_n_reg      <= byte_n_next;
            bit_nb_reg      <= bit_nb_next;
            bit_j_reg       <= bit_j_next;
            byte_idx_reg    <= byte_idx_next;
            rd_valid_reg    <= rd_valid_next;
            rd_slot_reg     <= rd_slot_next;
            done_reg        <= done_next;
            bit_valid_reg   <= bit_valid_next;
            if (cfg_write)
            begin
                if (paddr[2] == REG_BIT_LIMIT)
                    bit_limit_reg <= pwdata[LIMIT_W-1:0];
                else
                    byte_limit_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
        bits_reg   <= bits_next;
        acc_reg    <= acc_next;
        val_reg    <= val_next;
    end

    // Byte store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (byte_we)
            byte_mem[byte_waddr] <= byte_wdata;
        byte_rdata_reg <= byte_mem[byte_addr];
    end

    // Bit store: entries without a valid bit read as zero
    always_ff @(posedge clk)
    begin
        if (bit_we)
            bit_mem[bit_waddr] <= bit_wdata;
        bit_rdata_reg  <= bit_mem[bit_addr];
        bit_rvalid_reg <= bit_valid_reg[bit_addr];
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted without entering work");

    a_byte_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        32'(byte_cursor_reg) <= 32'(BYTE_DEPTH))
        else $error("byte cursor beyond store depth");

    a_bit_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bit_cursor_reg) <= 32'(BIT_DEPTH))
        else $error("bit cursor beyond store depth");

    a_error_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !ok_reg) |-> (bit_n_reg == 6'd0 && byte_n_reg == 4'd0))
        else $error("failed transaction would move a cursor");

endmodule
